// File: sv/cfa_pkg.sv
// Shared types and codes for the contiguous first-fit block allocator.
package cfa_pkg;

   // Field widths of the transaction payloads
   localparam int MODE_W   = 2;
   localparam int FID_W    = 16;
   localparam int SIZE_W   = 11;
   localparam int STATUS_W = 3;
   localparam int SLOT_W   = 5;
   localparam int BLK_W    = 10;

   // Command codes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LIST   = 2'd2;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOSPACE  = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOTFOUND = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_BADSIZE  = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd5;

   // Request transaction
   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [FID_W-1:0]  file_id;
      logic [SIZE_W-1:0] size;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   slot;
      logic [FID_W-1:0]    result_id;
      logic [BLK_W-1:0]    start_block;
      logic [BLK_W-1:0]    end_block;
      logic                last;
   } rsp_type;

   // Operations on the file table for one cycle
   typedef struct packed {
      logic wr;
      logic rd;
      logic set_valid;
      logic clr_valid;
   } tbl_op_type;

endpackage

// File: sv/cfa_step.sv
// Shared counter step unit: increment and end-of-range compare.
module cfa_step #(
   parameter int W = 10
) (
   input  logic [W-1:0] cnt,
   input  logic [W-1:0] limit,
   output logic [W-1:0] nxt,
   output logic         at_limit
);

   // Advance the sweep counter and flag the final position
   assign nxt      = cnt + W'(1);
   assign at_limit = (cnt == limit);

endmodule

// File: sv/cfa_bitmap.sv
// Block-used bitmap memory with one address port and registered read.
module cfa_bitmap #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic          clock,
   input  logic          we,
   input  logic          wbit,
   input  logic          re,
   input  logic [AW-1:0] addr,
   output logic          rbit
);

   logic bits_mem [DEPTH];
   logic rbit_ff;

   // Write one block flag, read one block flag
   always_ff @(posedge clock) begin
      if (we) begin
         bits_mem[addr] <= wbit;
      end
      if (re) begin
         rbit_ff <= bits_mem[addr];
      end
   end

   assign rbit = rbit_ff;

endmodule

// File: sv/cfa_table.sv
// File table: valid flags in flip-flops, id and block range in a memory.
module cfa_table
   import cfa_pkg::*;
#(
   parameter int ENTRIES = 32,
   parameter int SW      = 5,
   parameter int EW      = 36
) (
   input  logic          clock,
   input  logic          reset,
   input  tbl_op_type    op,
   input  logic [SW-1:0] waddr,
   input  logic [EW-1:0] wdata,
   input  logic [SW-1:0] raddr,
   output logic [EW-1:0] rdata,
   output logic          vbit
);

   logic [ENTRIES-1:0] valid_ff;
   logic [ENTRIES-1:0] valid_in;
   logic [EW-1:0]      entry_mem [ENTRIES];
   logic [EW-1:0]      rdata_ff;

   // Set or drop the valid flag of the addressed slot
   always_comb begin
      valid_in = valid_ff;
      priority if (op.set_valid) begin
         valid_in[waddr] = 1'b1;
      end else if (op.clr_valid) begin
         valid_in[waddr] = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Entry store: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (op.wr) begin
         entry_mem[waddr] <= wdata;
      end
      if (op.rd) begin
         rdata_ff <= entry_mem[raddr];
      end
   end

   assign rdata = rdata_ff;
   assign vbit  = valid_ff[raddr];

endmodule

// File: sv/contiguous_first_fit_allocator.sv
// Contiguous first-fit allocator: sequencer, table, bitmap and response register.
// Insert: a free table slot is searched, then the bitmap is scanned for a free run
//   (one block per cycle), the run is marked used and a response is emitted.
// Delete: slots are read until the id matches, then the run is freed and a response emitted.
// List: every table slot is read, held by response stalls; one request in flight at a time.
// Reset: valid flags clear at once; the bitmap is swept clear first.
module contiguous_first_fit_allocator
   import cfa_pkg::*;
#(
   parameter int BLOCKS   = 1024,
   parameter int ENTRIES  = 32,
   parameter int ID_WIDTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(BLOCKS);
   localparam int SW = $clog2(ENTRIES);
   localparam int CW = (AW > SW) ? AW : SW;
   localparam int IW = ID_WIDTH;
   localparam int EW = IW + 2 * AW;

   typedef enum logic [11:0] {
      ST_CLEAR     = 12'b0000_0000_0001,
      ST_IDLE      = 12'b0000_0000_0010,
      ST_FIND_SLOT = 12'b0000_0000_0100,
      ST_SCAN      = 12'b0000_0000_1000,
      ST_MARK      = 12'b0000_0001_0000,
      ST_DEL_READ  = 12'b0000_0010_0000,
      ST_DEL_EVAL  = 12'b0000_0100_0000,
      ST_FREE      = 12'b0000_1000_0000,
      ST_LIST_READ = 12'b0001_0000_0000,
      ST_LIST_EVAL = 12'b0010_0000_0000,
      ST_LIST_DONE = 12'b0100_0000_0000,
      ST_EMIT      = 12'b1000_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic [IW-1:0]      fid_ff, fid_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [SIZE_W-1:0]  rem_ff, rem_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [AW-1:0]      start_ff, start_in;
   logic [AW-1:0]      end_ff, end_in;
   logic [AW-1:0]      didx_ff, didx_in;
   logic               done_ff, done_in;
   logic               dvalid_ff, dvalid_in;
   logic               dlast_ff, dlast_in;
   logic               pend_ff, pend_in;
   rsp_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [CW-1:0]      step_limit;
   logic [CW-1:0]      cnt_nxt;
   logic               cnt_at_limit;
   logic               bm_we;
   logic               bm_wbit;
   logic               bm_re;
   logic               bm_rbit;
   tbl_op_type         tbl_op;
   logic [EW-1:0]      tbl_wdata;
   logic [EW-1:0]      tbl_rdata;
   logic               tbl_vbit;
   logic [IW-1:0]      tbl_rid;
   logic [AW-1:0]      tbl_rstart;
   logic [AW-1:0]      tbl_rend;
   logic               can_emit;
   logic               emit_go;
   rsp_type            emit_data;
   logic [IW-1:0]      fid_new;
   logic               size_bad;

   // Build one response transaction, fields cut to their port widths
   function automatic rsp_type mk_rsp(input logic [STATUS_W-1:0] status,
                                      input logic [SW-1:0] slot,
                                      input logic [IW-1:0] id,
                                      input logic [AW-1:0] first,
                                      input logic [AW-1:0] final_blk,
                                      input logic last);
      rsp_type r;
      r.status      = status;
      r.slot        = SLOT_W'(slot);
      r.result_id   = FID_W'(id);
      r.start_block = BLK_W'(first);
      r.end_block   = BLK_W'(final_blk);
      r.last        = last;
      return r;
   endfunction

   // Pick the end of the current sweep for the shared step unit
   always_comb begin
      priority if (state_ff == ST_MARK || state_ff == ST_FREE) begin
         step_limit = CW'(end_ff);
      end else if (state_ff == ST_SCAN || state_ff == ST_CLEAR) begin
         step_limit = CW'(BLOCKS - 1);
      end else begin
         step_limit = CW'(ENTRIES - 1);
      end
   end

   cfa_step #(
      .W (CW)
   ) u_step (
      .cnt      (cnt_ff),
      .limit    (step_limit),
      .nxt      (cnt_nxt),
      .at_limit (cnt_at_limit)
   );

   cfa_bitmap #(
      .DEPTH (BLOCKS),
      .AW    (AW)
   ) u_bitmap (
      .clock (clock),
      .we    (bm_we),
      .wbit  (bm_wbit),
      .re    (bm_re),
      .addr  (cnt_ff[AW-1:0]),
      .rbit  (bm_rbit)
   );

   cfa_table #(
      .ENTRIES (ENTRIES),
      .SW      (SW),
      .EW      (EW)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .op    (tbl_op),
      .waddr (slot_ff),
      .wdata (tbl_wdata),
      .raddr (cnt_ff[SW-1:0]),
      .rdata (tbl_rdata),
      .vbit  (tbl_vbit)
   );

   // Split the table read word
   assign tbl_rid    = tbl_rdata[EW-1 -: IW];
   assign tbl_rstart = tbl_rdata[2*AW-1 -: AW];
   assign tbl_rend   = tbl_rdata[AW-1:0];
   assign tbl_wdata  = {fid_ff, start_ff, end_ff};

   assign fid_new  = IW'(req_data.file_id);
   assign size_bad = (req_data.size == '0) || (32'(req_data.size) > 32'(BLOCKS));
   assign can_emit = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      fid_in    = fid_ff;
      size_in   = size_ff;
      rem_in    = rem_ff;
      slot_in   = slot_ff;
      start_in  = start_ff;
      end_in    = end_ff;
      done_in   = done_ff;
      pend_in   = pend_ff;
      res_in    = res_ff;
      dvalid_in = 1'b0;
      dlast_in  = 1'b0;
      didx_in   = cnt_ff[AW-1:0];
      bm_we     = 1'b0;
      bm_wbit   = 1'b0;
      bm_re     = 1'b0;
      tbl_op    = '0;
      emit_go   = 1'b0;
      emit_data = res_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            bm_we = 1'b1;
            if (cnt_at_limit) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_nxt;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               fid_in  = fid_new;
               size_in = req_data.size;
               cnt_in  = '0;
               pend_in = 1'b0;
               unique case (req_data.mode)
                  MODE_INSERT: begin
                     if (size_bad) begin
                        res_in   = mk_rsp(STATUS_BADSIZE, '0, fid_new, '0, '0, 1'b1);
                        state_in = ST_EMIT;
                     end else begin
                        state_in = ST_FIND_SLOT;
                     end
                  end
                  MODE_DELETE: state_in = ST_DEL_READ;
                  MODE_LIST:   state_in = ST_LIST_READ;
                  default:     state_in = ST_IDLE;
               endcase
            end
         end

         ST_FIND_SLOT: begin
            if (!tbl_vbit) begin
               slot_in  = cnt_ff[SW-1:0];
               cnt_in   = '0;
               rem_in   = size_ff;
               start_in = '0;
               done_in  = 1'b0;
               state_in = ST_SCAN;
            end else if (cnt_at_limit) begin
               res_in   = mk_rsp(STATUS_FULL, '0, fid_ff, '0, '0, 1'b1);
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_nxt;
            end
         end

         ST_SCAN: begin
            // issue the next bitmap read
            if (!done_ff) begin
               bm_re     = 1'b1;
               dvalid_in = 1'b1;
               dlast_in  = cnt_at_limit;
               didx_in   = cnt_ff[AW-1:0];
               cnt_in    = cnt_nxt;
               done_in   = cnt_at_limit;
            end
            // evaluate the flag read in the previous cycle
            if (dvalid_ff) begin
               if (bm_rbit) begin
                  rem_in   = size_ff;
                  start_in = didx_ff + AW'(1);
                  if (dlast_ff) begin
                     res_in   = mk_rsp(STATUS_NOSPACE, '0, fid_ff, '0, '0, 1'b1);
                     state_in = ST_EMIT;
                  end
               end else if (rem_ff == SIZE_W'(1)) begin
                  end_in   = didx_ff;
                  cnt_in   = CW'(start_ff);
                  state_in = ST_MARK;
               end else begin
                  rem_in = rem_ff - SIZE_W'(1);
                  if (dlast_ff) begin
                     res_in   = mk_rsp(STATUS_NOSPACE, '0, fid_ff, '0, '0, 1'b1);
                     state_in = ST_EMIT;
                  end
               end
            end
         end

         ST_MARK: begin
            bm_we   = 1'b1;
            bm_wbit = 1'b1;
            if (cnt_at_limit) begin
               tbl_op.wr        = 1'b1;
               tbl_op.set_valid = 1'b1;
               res_in   = mk_rsp(STATUS_OK, slot_ff, fid_ff, start_ff, end_ff, 1'b1);
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_nxt;
            end
         end

         ST_DEL_READ: begin
            tbl_op.rd = 1'b1;
            state_in  = ST_DEL_EVAL;
         end

         ST_DEL_EVAL: begin
            if (tbl_vbit && (tbl_rid == fid_ff)) begin
               slot_in  = cnt_ff[SW-1:0];
               start_in = tbl_rstart;
               end_in   = tbl_rend;
               cnt_in   = CW'(tbl_rstart);
               state_in = ST_FREE;
            end else if (cnt_at_limit) begin
               res_in   = mk_rsp(STATUS_NOTFOUND, '0, fid_ff, '0, '0, 1'b1);
               state_in = ST_EMIT;
            end else begin
               cnt_in   = cnt_nxt;
               state_in = ST_DEL_READ;
            end
         end

         ST_FREE: begin
            bm_we = 1'b1;
            if (cnt_at_limit) begin
               tbl_op.clr_valid = 1'b1;
               res_in   = mk_rsp(STATUS_OK, slot_ff, fid_ff, start_ff, end_ff, 1'b1);
               state_in = ST_EMIT;
            end else begin
               cnt_in = cnt_nxt;
            end
         end

         ST_LIST_READ: begin
            tbl_op.rd = 1'b1;
            state_in  = ST_LIST_EVAL;
         end

         ST_LIST_EVAL: begin
            // hold while an earlier entry still waits for the response register
            if (!(tbl_vbit && pend_ff && !can_emit)) begin
               if (tbl_vbit) begin
                  emit_go = pend_ff;
                  res_in  = mk_rsp(STATUS_OK, cnt_ff[SW-1:0], tbl_rid, tbl_rstart,
                                   tbl_rend, 1'b0);
                  pend_in = 1'b1;
               end
               if (cnt_at_limit) begin
                  state_in = ST_LIST_DONE;
               end else begin
                  cnt_in   = cnt_nxt;
                  state_in = ST_LIST_READ;
               end
            end
         end

         ST_LIST_DONE: begin
            if (pend_ff) begin
               res_in.last = 1'b1;
            end else begin
               res_in = mk_rsp(STATUS_EMPTY, '0, '0, '0, '0, 1'b1);
            end
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (can_emit) begin
               emit_go  = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Response register: load on emit, drop once taken
   always_comb begin
      rsp_in = rsp_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_data;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         done_ff      <= 1'b0;
         dvalid_ff    <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         done_ff      <= done_in;
         dvalid_ff    <= dvalid_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload state
   always_ff @(posedge clock) begin
      fid_ff   <= fid_in;
      size_ff  <= size_in;
      rem_ff   <= rem_in;
      slot_ff  <= slot_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      didx_ff  <= didx_in;
      dlast_ff <= dlast_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Marking and freeing stay inside the entry's run
   a_run_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK || state_ff == ST_FREE) |->
         (cnt_ff[AW-1:0] >= start_ff && cnt_ff[AW-1:0] <= end_ff))
      else $error("bitmap sweep left the run");

   // A real command leaves idle
   a_cmd_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.mode != MODE_UNUSED) |=> (state_ff != ST_IDLE))
      else $error("accepted command did not start");

   // No response during the clearing pass
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("response during bitmap clear");

   // Never overwrite a response that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      emit_go |-> (!rsp_valid_ff || !rsp_stall))
      else $error("response overwritten");

endmodule
